// ===== design/omcu_pkg.sv =====
`timescale 1ns / 1ps
// omcu_pkg: widths, request and status codes, and sequencer states
// for online_mean_covariance_update; no dependencies
package omcu_pkg;

    localparam int MAX_DIM     = 16;
    localparam int MAX_SAMPLES = 4095;
    localparam int FRAC_BITS   = 8;

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = 5;
    localparam int CNT_W  = 12;
    localparam int X_W    = 16;
    localparam int PROD_W = 2 * X_W;
    localparam int ES_W   = 28;
    localparam int PS_W   = 43;
    localparam int NS_W   = CNT_W + 1 + PS_W;
    localparam int SS_W   = 2 * ES_W;
    localparam int D_W    = 57;
    localparam int NUM_W  = D_W + FRAC_BITS;
    localparam int DEN_W  = 2 * CNT_W;
    localparam int DCNT_W = $clog2(NUM_W);
    localparam int OUT_W  = 41;
    localparam int PS_DEPTH = MAX_DIM * MAX_DIM;

    localparam logic [1:0] REQ_PUSH     = 2'd0;
    localparam logic [1:0] REQ_READ_COV = 2'd1;
    localparam logic [1:0] REQ_READ_MEAN = 2'd2;
    localparam logic [1:0] REQ_RESTART  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MRD  = 8'b0000_0010,
        S_MWR  = 8'b0000_0100,
        S_RRD  = 8'b0000_1000,
        S_RMUL = 8'b0001_0000,
        S_RSUB = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

endpackage

// ===== design/online_mean_covariance_update.sv =====
`timescale 1ns / 1ps
// online_mean_covariance_update: running mean and population covariance
// of sample vectors, exact sums with a bit-serial divider; uses omcu_pkg
//
// usage
//   input channel (in_valid / in_stall): one request per transfer; push
//   an element, read a covariance entry, read a mean entry, or restart
//   output channel (out_valid / out_stall): one result per read request,
//   none for push or restart; results come in request order
//   config channel (cfg_valid / cfg_ready): vector_dim, always ready;
//   write it only while the block is idle
// timing
//   plain push and restart: the block stays idle, in_stall stays low
//   push that completes a sample: for each of the dim*dim entries, one
//   multiply-accumulate into the product-sum memory in S_MRD and S_MWR
//   (read, then add and write back through its single port)
//   read: S_RRD, S_RMUL, S_RSUB, then the one-bit-per-cycle divider
//   in_stall stays high while a request is being worked on
// reset
//   sums read as zero through per-entry valid bits, count and position
//   clear at once, vector_dim goes to 2; no clearing pass
// back-pressure
//   a finished result sits in the output register until taken; a new
//   result waits in the final state while the old one is still stalled
module online_mean_covariance_update
    import omcu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              req_type,
    input  logic signed [X_W-1:0]   sample_value,
    input  logic [3:0]              row_index,
    input  logic [3:0]              col_index,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] read_value,
    output logic [CNT_W-1:0]        samples_seen,
    output logic [1:0]              read_status,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [DIM_W-1:0]        vector_dim
);

    // control state
    state_t                 state_reg, state_next;
    logic [DIM_W-1:0]       dim_cfg_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       i_reg, i_next;
    logic [IDX_W-1:0]       j_reg, j_next;
    logic                   is_cov_reg;
    logic [1:0]             status_reg;
    logic [MAX_DIM-1:0]     es_valid_reg;
    logic [PS_DEPTH-1:0]    ps_valid_reg;
    logic [DCNT_W-1:0]      div_cnt_reg;
    logic                   out_valid_reg;

    // memories
    logic signed [X_W-1:0]  part_mem [MAX_DIM];
    logic signed [ES_W-1:0] es_mem   [MAX_DIM];
    logic signed [PS_W-1:0] ps_mem   [PS_DEPTH];

    // registered read data
    logic signed [X_W-1:0]  p_i_reg, p_j_reg;
    logic signed [ES_W-1:0] es_a_reg, es_b_reg;
    logic signed [PS_W-1:0] ps_rd_reg;
    logic                   es_va_reg, es_vb_reg, ps_v_reg;

    // datapath registers
    logic signed [NS_W-1:0] nsxx_reg;
    logic signed [SS_W-1:0] sxsx_reg;
    logic [DEN_W-1:0]       den_reg;
    logic                   neg_reg;
    logic [DEN_W-1:0]       rem_reg;
    logic [NUM_W-1:0]       quo_reg;
    logic signed [OUT_W-1:0] value_reg;
    logic [CNT_W-1:0]       seen_reg;
    logic [1:0]             rstat_reg;

    logic [DIM_W-1:0]       dim;
    logic [DIM_W-1:0]       dim_m1;
    logic                   accept;
    logic                   out_free;
    logic                   j_last, i_last;
    logic [IDX_W*2-1:0]     ps_addr;
    logic signed [ES_W-1:0] es_a_eff, es_b_eff;
    logic signed [PS_W-1:0] ps_eff;
    logic signed [PROD_W-1:0] mac_prod;
    logic signed [PS_W-1:0] ps_new;
    logic signed [ES_W-1:0] es_new;
    logic signed [CNT_W:0]  n_s;
    logic signed [D_W-1:0]  num;
    logic [D_W-1:0]         mag;
    logic [DEN_W:0]         trial;
    logic                   pos_over, neg_over;
    logic signed [OUT_W-1:0] sat_value;
    logic                   bad_idx;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // active dimension: zero acts as one, large values clamp
    always_comb
    begin
        if (dim_cfg_reg == '0)
            dim = DIM_W'(1);
        else if (dim_cfg_reg > DIM_W'(MAX_DIM))
            dim = DIM_W'(MAX_DIM);
        else
            dim = dim_cfg_reg;
    end
    assign dim_m1 = dim - DIM_W'(1);

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign read_value   = value_reg;
    assign samples_seen = seen_reg;
    assign read_status  = rstat_reg;

    assign ps_addr = {i_reg, j_reg};
    assign j_last  = ({1'b0, j_reg} == dim_m1);
    assign i_last  = ({1'b0, i_reg} == dim_m1);

    // entries never written since restart read as zero
    assign es_a_eff = es_va_reg ? es_a_reg : '0;
    assign es_b_eff = es_vb_reg ? es_b_reg : '0;
    assign ps_eff   = ps_v_reg ? ps_rd_reg : '0;

    assign mac_prod = p_i_reg * p_j_reg;
    assign ps_new   = ps_eff + PS_W'(mac_prod);
    assign es_new   = es_a_eff + ES_W'(p_i_reg);

    assign n_s = signed'({1'b0, count_reg});

    assign num = is_cov_reg ? (D_W'(nsxx_reg) - D_W'(sxsx_reg)) : D_W'(es_a_eff);
    assign mag = num[D_W-1] ? D_W'(-num) : D_W'(num);

    assign trial = {rem_reg, quo_reg[NUM_W-1]} - {1'b0, den_reg};

    // saturate the signed quotient to the output range
    assign pos_over = |quo_reg[NUM_W-1:OUT_W-1];
    assign neg_over = (|quo_reg[NUM_W-1:OUT_W])
                   || (quo_reg[OUT_W-1] && (|quo_reg[OUT_W-2:0]));
    always_comb
    begin
        if (neg_reg)
            sat_value = neg_over ? OUT_MIN : -signed'(quo_reg[OUT_W-1:0]);
        else
            sat_value = pos_over ? OUT_MAX : signed'(quo_reg[OUT_W-1:0]);
    end

    assign bad_idx = ({1'b0, row_index} >= dim)
                  || ((req_type == REQ_READ_COV) && ({1'b0, col_index} >= dim));

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_PUSH:
                        begin
                            if ((count_reg < CNT_W'(MAX_SAMPLES))
                                && (({1'b0, pos_reg} + DIM_W'(1)) >= dim))
                            begin
                                state_next = S_MRD;
                                i_next     = '0;
                                j_next     = '0;
                            end
                        end
                        REQ_READ_COV, REQ_READ_MEAN:
                        begin
                            i_next = row_index;
                            j_next = col_index;
                            if (bad_idx || (count_reg == '0))
                                state_next = S_FIN;
                            else
                                state_next = S_RRD;
                        end
                        REQ_RESTART:
                        begin
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MRD:
            begin
                state_next = S_MWR;
            end
            S_MWR:
            begin
                if (j_last)
                begin
                    j_next = '0;
                    if (i_last)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = S_MRD;
                    end
                end
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_MRD;
                end
            end
            S_RRD:
            begin
                state_next = S_RMUL;
            end
            S_RMUL:
            begin
                state_next = S_RSUB;
            end
            S_RSUB:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DCNT_W'(NUM_W - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dim_cfg_reg   <= DIM_W'(2);
            pos_reg       <= '0;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            is_cov_reg    <= 1'b0;
            status_reg    <= ST_OK;
            es_valid_reg  <= '0;
            ps_valid_reg  <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;

            if (cfg_valid && cfg_ready)
                dim_cfg_reg <= vector_dim;

            if (accept)
            begin
                unique case (req_type)
                    REQ_PUSH:
                    begin
                        if (count_reg < CNT_W'(MAX_SAMPLES))
                        begin
                            if (({1'b0, pos_reg} + DIM_W'(1)) >= dim)
                            begin
                                pos_reg   <= '0;
                                count_reg <= count_reg + CNT_W'(1);
                            end
                            else
                                pos_reg <= pos_reg + IDX_W'(1);
                        end
                    end
                    REQ_READ_COV, REQ_READ_MEAN:
                    begin
                        is_cov_reg <= (req_type == REQ_READ_COV);
                        if (bad_idx)
                            status_reg <= ST_BAD_INDEX;
                        else if (count_reg == '0)
                            status_reg <= ST_EMPTY;
                        else
                            status_reg <= ST_OK;
                    end
                    REQ_RESTART:
                    begin
                        es_valid_reg <= '0;
                        ps_valid_reg <= '0;
                        pos_reg      <= '0;
                        count_reg    <= '0;
                    end
                    default:
                    begin
                        pos_reg <= pos_reg;
                    end
                endcase
            end

            if (state_reg == S_MWR)
            begin
                ps_valid_reg[ps_addr] <= 1'b1;
                if (j_reg == '0)
                    es_valid_reg[i_reg] <= 1'b1;
            end

            if (state_reg == S_RSUB)
                div_cnt_reg <= '0;
            else if (state_reg == S_DIV)
                div_cnt_reg <= div_cnt_reg + DCNT_W'(1);

            if ((state_reg == S_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // memories and their registered reads
    always_ff @(posedge clk)
    begin
        if (accept && (req_type == REQ_PUSH) && (count_reg < CNT_W'(MAX_SAMPLES)))
            part_mem[pos_reg] <= sample_value;
        if (state_reg == S_MWR)
        begin
            ps_mem[ps_addr] <= ps_new;
            if (j_reg == '0)
                es_mem[i_reg] <= es_new;
        end
        p_i_reg   <= part_mem[i_reg];
        p_j_reg   <= part_mem[j_reg];
        es_a_reg  <= es_mem[i_reg];
        es_b_reg  <= es_mem[j_reg];
        ps_rd_reg <= ps_mem[ps_addr];
        es_va_reg <= es_valid_reg[i_reg];
        es_vb_reg <= es_valid_reg[j_reg];
        ps_v_reg  <= ps_valid_reg[ps_addr];
    end

    // read datapath: products, magnitude, bit-serial divide, result
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RMUL)
        begin
            nsxx_reg <= n_s * ps_eff;
            sxsx_reg <= es_a_eff * es_b_eff;
            den_reg  <= is_cov_reg ? (count_reg * count_reg) : DEN_W'(count_reg);
        end
        if (state_reg == S_RSUB)
        begin
            neg_reg <= num[D_W-1];
            rem_reg <= '0;
            quo_reg <= NUM_W'(mag) << FRAC_BITS;
        end
        else if (state_reg == S_DIV)
        begin
            if (!trial[DEN_W])
            begin
                rem_reg <= trial[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DEN_W-2:0], quo_reg[NUM_W-1]};
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
        if ((state_reg == S_FIN) && out_free)
        begin
            value_reg <= (status_reg == ST_OK) ? sat_value : '0;
            seen_reg  <= count_reg;
            rstat_reg <= status_reg;
        end
    end

    // checks
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count past its limit");

    a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (rstat_reg != ST_OK)) |-> (value_reg == '0))
        else $error("flagged result carries a value");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_cnt_reg < DCNT_W'(NUM_W)))
        else $error("divider ran too long");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the final state");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for online_mean_covariance_update, with a built-in
// running sum predictor, directed table, random phases; uses omcu_pkg and the rtl
module tb;
    import omcu_pkg::*;

    // generous cycle limit, far above the slowest legal run
    localparam int CYCLE_LIMIT = 5000000;
    localparam int DRAIN_GAP   = 600;   // longer than a 16-wide sample update
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic [CNT_W-1:0]        count;
        logic [1:0]              status;
    } read_result_t;

    typedef struct {
        logic [1:0]  req;
        logic [15:0] sample;
        logic [3:0]  row;
        logic [3:0]  col;
        bit          typed;
        longint      value;
        int          count;
        logic [1:0]  status;
    } table_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              req_type;
    logic signed [X_W-1:0]   sample_value;
    logic [3:0]              row_index;
    logic [3:0]              col_index;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [OUT_W-1:0] read_value;
    logic [CNT_W-1:0]        samples_seen;
    logic [1:0]              read_status;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [DIM_W-1:0]        vector_dim;

    online_mean_covariance_update u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .sample_value (sample_value),
        .row_index    (row_index),
        .col_index    (col_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .samples_seen (samples_seen),
        .read_status  (read_status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .vector_dim   (vector_dim)
    );

    // predictor state: exact sums, partial sample, position, count
    logic [DIM_W-1:0] dim_reg;
    longint           sum_x  [MAX_DIM];
    longint           sum_xx [MAX_DIM][MAX_DIM];
    longint           partial[MAX_DIM];
    int               position;
    int               count;

    read_result_t pending_reads[$];
    int           errors;
    int           cycles;
    int           send_idle_pct;
    int           stall_pct;
    bit           hold_on;
    bit           hold_go;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int used_dim();
        int d;
        d = int'(dim_reg);
        if (d == 0) d = 1;
        if (d > MAX_DIM) d = MAX_DIM;
        return d;
    endfunction

    function automatic void clear_sums();
        for (int i = 0; i < MAX_DIM; i++)
        begin
            sum_x[i] = 0;
            for (int j = 0; j < MAX_DIM; j++)
                sum_xx[i][j] = 0;
        end
        position = 0;
        count    = 0;
    endfunction

    // trunc(num * 2^FRAC_BITS / den), split so nothing overflows, then saturate
    function automatic longint frac_div(input longint num, input longint den);
        longint q;
        longint r;
        longint v;
        q = num / den;
        r = num % den;
        v = q * (64'sd1 <<< FRAC_BITS) + (r * (64'sd1 <<< FRAC_BITS)) / den;
        if (v > 64'sd1099511627775) v = 64'sd1099511627775;
        if (v < -64'sd1099511627776) v = -64'sd1099511627776;
        return v;
    endfunction

    // applies one accepted request; returns 1 when a read result follows
    function automatic bit mean_cov_predict(input logic [1:0] rq, input logic [15:0] x,
                                            input logic [3:0] r, input logic [3:0] c,
                                            output read_result_t res);
        int     d;
        longint n;
        longint diff;
        d   = used_dim();
        res = '{value: '0, count: '0, status: ST_OK};
        if (rq == REQ_PUSH)
        begin
            if (count >= MAX_SAMPLES) return 0;
            partial[position] = longint'($signed(x));
            if (position + 1 >= d)
            begin
                for (int i = 0; i < d; i++)
                begin
                    sum_x[i] += partial[i];
                    for (int j = 0; j < d; j++)
                        sum_xx[i][j] += partial[i] * partial[j];
                end
                count++;
                position = 0;
            end
            else
                position++;
            return 0;
        end
        if (rq == REQ_RESTART)
        begin
            clear_sums();
            return 0;
        end
        res.count = count[CNT_W-1:0];
        if (int'(r) >= d || (rq == REQ_READ_COV && int'(c) >= d))
            res.status = ST_BAD_INDEX;
        else if (count == 0)
            res.status = ST_EMPTY;
        else
        begin
            n = count;
            if (rq == REQ_READ_MEAN)
                res.value = OUT_W'(frac_div(sum_x[r], n));
            else
            begin
                diff = n * sum_xx[r][c] - sum_x[r] * sum_x[c];
                res.value = OUT_W'(frac_div(diff, n * n));
            end
        end
        return 1;
    endfunction

    // one transfer on the request channel, with optional leading idle cycles
    task automatic send_req(input logic [1:0] rq, input logic [15:0] x,
                            input logic [3:0] r, input logic [3:0] c,
                            input bit typed, input read_result_t typed_res);
        read_result_t res;
        bit           has;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid     = 1'b1;
        req_type     = rq;
        sample_value = x;
        row_index    = r;
        col_index    = c;
        forever
        begin
            @(posedge clk);
            if (!in_stall) break;
        end
        has = mean_cov_predict(rq, x, r, c, res);
        if (has) pending_reads.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    task automatic write_dim(input logic [DIM_W-1:0] d);
        cfg_valid  = 1'b1;
        vector_dim = d;
        forever
        begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        dim_reg = d;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // let results drain, then wait out a possible sample update
    task automatic drain();
        in_valid = 1'b0;
        while (pending_reads.size() != 0) @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed traffic: pushes with reads mostly in range
    task automatic random_req();
        read_result_t none;
        int           pick;
        int           d;
        logic [3:0]   r;
        logic [3:0]   c;
        none = '{value: '0, count: '0, status: ST_OK};
        pick = $urandom_range(99);
        d    = used_dim();
        r    = ($urandom_range(9) < 8) ? 4'($urandom_range(d - 1)) : 4'($urandom);
        c    = ($urandom_range(9) < 8) ? 4'($urandom_range(d - 1)) : 4'($urandom);
        if (pick < 58)
            send_req(REQ_PUSH, pick_sample(), 4'($urandom), 4'($urandom), 0, none);
        else if (pick < 78)
            send_req(REQ_READ_COV, 16'($urandom), r, c, 0, none);
        else if (pick < 98)
            send_req(REQ_READ_MEAN, 16'($urandom), r, 4'($urandom), 0, none);
        else
            send_req(REQ_RESTART, 16'($urandom), 4'($urandom), 4'($urandom), 0, none);
    endtask

    // receiver: random stall, plus a long hold-off counted here
    always @(negedge clk)
        out_stall = hold_on || ($urandom_range(99) < stall_pct);

    initial
    begin
        wait (hold_go);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on = 1'b0;
    end

    // result checker: every transfer against the oldest expectation
    always @(posedge clk)
    begin
        read_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result value=%0d count=%0d status=%0d",
                         $time, read_value, samples_seen, read_status);
            end
            else
            begin
                exp_res = pending_reads.pop_front();
                if (read_value !== exp_res.value)
                begin
                    errors++;
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, exp_res.value, read_value);
                end
                if (samples_seen !== exp_res.count)
                begin
                    errors++;
                    $display("%0t: samples_seen expected %0d actual %0d",
                             $time, exp_res.count, samples_seen);
                end
                if (read_status !== exp_res.status)
                begin
                    errors++;
                    $display("%0t: read_status expected %0d actual %0d",
                             $time, exp_res.status, read_status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        table_row_t   directed[];
        read_result_t typed_res;
        logic [DIM_W-1:0] phase_dims[8];

        in_valid      = 1'b0;
        req_type      = REQ_PUSH;
        sample_value  = '0;
        row_index     = '0;
        col_index     = '0;
        cfg_valid     = 1'b0;
        vector_dim    = 5'd2;
        out_stall     = 1'b0;
        hold_on       = 1'b0;
        hold_go       = 1'b0;
        errors        = 0;
        cycles        = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        dim_reg       = 5'd2;
        for (int i = 0; i < MAX_DIM; i++) partial[i] = 0;
        clear_sums();

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part at the reset dimension of two
        directed = '{
            '{REQ_READ_MEAN, 16'h0000, 4'd0,  4'd0,  1, 0, 0, ST_EMPTY},
            '{REQ_READ_COV,  16'h0000, 4'd0,  4'd0,  1, 0, 0, ST_EMPTY},
            '{REQ_READ_MEAN, 16'h0000, 4'd2,  4'd0,  1, 0, 0, ST_BAD_INDEX},
            '{REQ_READ_COV,  16'h0000, 4'd0,  4'd2,  1, 0, 0, ST_BAD_INDEX},
            '{REQ_READ_COV,  16'h0000, 4'd15, 4'd15, 1, 0, 0, ST_BAD_INDEX},
            '{REQ_PUSH,      16'h7fff, 4'd0,  4'd0,  0, 0, 0, ST_OK},
            '{REQ_PUSH,      16'h8000, 4'd15, 4'd15, 0, 0, 0, ST_OK},
            '{REQ_READ_MEAN, 16'h0000, 4'd0,  4'd0,  1, 8388352, 1, ST_OK},
            '{REQ_READ_MEAN, 16'hffff, 4'd1,  4'd15, 1, -8388608, 1, ST_OK},
            '{REQ_READ_COV,  16'h0000, 4'd0,  4'd1,  1, 0, 1, ST_OK},
            '{REQ_READ_MEAN, 16'h0000, 4'd15, 4'd0,  1, 0, 1, ST_BAD_INDEX},
            '{REQ_PUSH,      16'h8000, 4'd0,  4'd0,  0, 0, 0, ST_OK},
            '{REQ_PUSH,      16'h7fff, 4'd0,  4'd0,  0, 0, 0, ST_OK},
            '{REQ_READ_MEAN, 16'h0000, 4'd0,  4'd0,  1, -128, 2, ST_OK},
            '{REQ_READ_COV,  16'h0000, 4'd0,  4'd0,  0, 0, 0, ST_OK},
            '{REQ_READ_COV,  16'h0000, 4'd1,  4'd0,  0, 0, 0, ST_OK},
            '{REQ_PUSH,      16'h0005, 4'd0,  4'd0,  0, 0, 0, ST_OK},
            '{REQ_RESTART,   16'h0000, 4'd0,  4'd0,  0, 0, 0, ST_OK},
            '{REQ_READ_MEAN, 16'h0000, 4'd0,  4'd0,  1, 0, 0, ST_EMPTY},
            '{REQ_PUSH,      16'h0000, 4'd0,  4'd0,  0, 0, 0, ST_OK},
            '{REQ_PUSH,      16'h0001, 4'd0,  4'd0,  0, 0, 0, ST_OK},
            '{REQ_READ_COV,  16'h0000, 4'd1,  4'd1,  1, 0, 1, ST_OK},
            '{REQ_READ_MEAN, 16'h0000, 4'd1,  4'd0,  1, 256, 1, ST_OK}
        };
        foreach (directed[k])
        begin
            typed_res.value  = OUT_W'(directed[k].value);
            typed_res.count  = CNT_W'(directed[k].count);
            typed_res.status = directed[k].status;
            send_req(directed[k].req, directed[k].sample, directed[k].row,
                     directed[k].col, directed[k].typed, typed_res);
        end
        drain();

        // random phases; dimension may change with a sample half built
        phase_dims = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd5, 5'd17, 5'd2, 5'($urandom)};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_dim(phase_dims[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            if (ph == 4) hold_go = 1'b1;   // long receiver hold-off fills the block
            for (int k = 0; k < 215; k++) random_req();
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
